@@ hdl/quadratic_spline_segment_fitter_top_defines.svh @@
`ifndef QUADRATIC_SPLINE_SEGMENT_FITTER_TOP_DEFINES_SVH
`define QUADRATIC_SPLINE_SEGMENT_FITTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define QSSF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define QSSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/qssf_pkg.sv @@
`default_nettype none

package qssf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int DATA_IN_W  = 2 * WORD_W;
    localparam int DATA_OUT_W = 5 * WORD_W;
    localparam int MUL_W      = 32;
    localparam int MUL_CNT_W  = $clog2(MUL_W + 1);
    localparam int PROD_W     = 2 * MUL_W;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
    localparam int DIFF_W     = PROD_W + 2;
    localparam int QUO_W      = 32;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ORDER = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL1,
        ST_FORM,
        ST_DLOAD,
        ST_DIV,
        ST_MUL2,
        ST_EMIT
    } fit_state_t;

    typedef struct packed {
        logic done;
        logic over;
    } div_status_t;

endpackage

`default_nettype wire

@@ hdl/qssf_ser_mul.sv @@
`default_nettype none

module qssf_ser_mul (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [qssf_pkg::MUL_W-1:0]      mcand,
    input  wire logic [qssf_pkg::MUL_W-1:0]      mplier,
    output logic                                 done,
    output logic      [qssf_pkg::PROD_W-1:0]     prod
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [qssf_pkg::MUL_CNT_W-1:0]    cnt_reg;
    logic [qssf_pkg::MUL_W-1:0]        mcand_reg;
    logic [qssf_pkg::MUL_W-1:0]        mplier_reg;
    logic [qssf_pkg::PROD_W-1:0]       acc_reg;
    logic [qssf_pkg::PROD_W-1:0]       acc_next;

    // msb first shift-add, one multiplier bit per cycle
    always_comb begin
        acc_next = {acc_reg[qssf_pkg::PROD_W-2:0], 1'b0};
        if (mplier_reg[qssf_pkg::MUL_W-1]) begin
            acc_next = acc_next + qssf_pkg::PROD_W'(mcand_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= qssf_pkg::MUL_CNT_W'(qssf_pkg::MUL_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - qssf_pkg::MUL_CNT_W'(1);
                if (cnt_reg == qssf_pkg::MUL_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            acc_reg    <= '0;
        end else if (busy_reg) begin
            mplier_reg <= {mplier_reg[qssf_pkg::MUL_W-2:0], 1'b0};
            acc_reg    <= acc_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

@@ hdl/qssf_ser_div.sv @@
`default_nettype none

module qssf_ser_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [qssf_pkg::NUM_W-1:0]      num,
    input  wire logic [qssf_pkg::PROD_W-1:0]     den,
    output qssf_pkg::div_status_t                status,
    output logic      [qssf_pkg::QUO_W-1:0]      quo
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [qssf_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [qssf_pkg::NUM_W-1:0]        num_reg;
    logic [qssf_pkg::PROD_W-1:0]       den_reg;
    logic [qssf_pkg::PROD_W-1:0]       rem_reg;
    logic [qssf_pkg::QUO_W-1:0]        quo_reg;
    logic                              over_reg;

    logic [qssf_pkg::PROD_W:0]         trial;
    logic [qssf_pkg::PROD_W:0]         trial_sub;
    logic                              ge;
    logic [qssf_pkg::PROD_W-1:0]       rem_next;

    // restoring long division, one quotient bit per cycle
    always_comb begin
        trial     = {rem_reg, num_reg[qssf_pkg::NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        rem_next  = ge ? trial_sub[qssf_pkg::PROD_W-1:0] : trial[qssf_pkg::PROD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= qssf_pkg::DIV_CNT_W'(qssf_pkg::NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - qssf_pkg::DIV_CNT_W'(1);
                if (cnt_reg == qssf_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quo_reg  <= '0;
            over_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg  <= {num_reg[qssf_pkg::NUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[qssf_pkg::QUO_W-2:0], ge};
            // a one pushed past the top means the quotient no longer fits
            over_reg <= over_reg | quo_reg[qssf_pkg::QUO_W-1];
        end
    end

    assign status.done = done_reg;
    assign status.over = over_reg;
    assign quo         = quo_reg;

endmodule

`default_nettype wire

@@ hdl/quadratic_spline_segment_fitter_top.sv @@
// latency: run-start and ignored samples are absorbed at acceptance, ready again next cycle
// a non-increasing position goes from PREP straight to EMIT with an order result
// curved piece: PREP, MUL1, FORM, DLOAD, DIV, MUL2, EMIT; secant piece: PREP, DIV, EMIT
// throughput: one sample at a time, set by the bit-serial divider (64+FRAC_BITS steps)
//   and, for a curved piece, two passes of the 32-step serial multiplier
// reset: synchronous active-low aresetn clears run state, sequencer and output valid
`default_nettype none

module quadratic_spline_segment_fitter_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // sample_position, sample_value
    input  wire logic [qssf_pkg::DATA_IN_W-1:0]      s_tdata,
    // run_start
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // piece_left_position, piece_left_value, piece_slope, piece_curvature,
    // piece_right_position
    output logic      [qssf_pkg::DATA_OUT_W-1:0]     m_tdata,
    // fit_status
    output logic      [1:0]                          m_tuser
);

    localparam int W  = qssf_pkg::WORD_W;
    localparam int F  = qssf_pkg::FRAC_BITS;
    localparam int PW = qssf_pkg::PROD_W;
    localparam int DW = qssf_pkg::DIFF_W;

    localparam logic [1:0] SEEN_NONE  = 2'd0;
    localparam logic [1:0] SEEN_ONE   = 2'd1;
    localparam logic [1:0] SEEN_SLOPE = 2'd2;

    qssf_pkg::fit_state_t state_reg;
    qssf_pkg::fit_state_t state_next;

    logic [W-1:0]  prev_pos_reg;
    logic [W-1:0]  prev_val_reg;
    logic [W-1:0]  slope_reg;
    logic [1:0]    seen_reg;
    logic          halted_reg;

    logic [W-1:0]  x_reg;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  h_reg;
    logic [W:0]    dy_reg;
    logic [DW-1:0] diff_reg;
    logic          neg_reg;
    logic          order_reg;
    logic          sat_reg;
    logic [W-1:0]  c_reg;
    logic [W-1:0]  ns_reg;
    logic [W-1:0]  slope_out_reg;

    logic                               m_valid_reg;
    logic [qssf_pkg::DATA_OUT_W-1:0]    m_data_reg;
    logic [1:0]                         m_user_reg;

    logic          in_acc;
    logic          out_free;
    logic          out_load;
    logic          div_start;
    logic          mul_a_start;
    logic          mul_b_start;

    logic [W:0]    h_full;
    logic [W:0]    dy_full;
    logic [W:0]    dy_mag;
    logic          h_bad;
    logic [W-1:0]  slope_mag;
    logic [DW-1:0] a_ext;
    logic [DW-1:0] pa_ext;
    logic [DW-1:0] diff_mag;

    logic [qssf_pkg::NUM_W-1:0] div_num;
    logic [PW-1:0]              div_den;
    qssf_pkg::div_status_t      div_stat;
    logic [qssf_pkg::QUO_W-1:0] div_quo;
    logic                       q_big;
    logic                       div_sat;
    logic [W-1:0]               div_val;
    logic [W-1:0]               c_mag;

    logic [qssf_pkg::MUL_W-1:0] mul_a_mcand;
    logic [qssf_pkg::MUL_W-1:0] mul_a_mplier;
    logic                       mul_a_done;
    logic [PW-1:0]              mul_a_prod;
    logic                       mul_b_done;
    logic [PW-1:0]              mul_b_prod;

    logic [DW-1:0] s_ext;
    logic [DW-1:0] sh_ext;
    logic [DW-1:0] ns_sum;
    logic          ns_ovf;
    logic [W-1:0]  ns_sat;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        div_start   = 1'b0;
        mul_a_start = 1'b0;
        mul_b_start = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            qssf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && !s_tuser && seen_reg != SEEN_NONE && !halted_reg) begin
                    state_next = qssf_pkg::ST_PREP;
                end
            end
            qssf_pkg::ST_PREP: begin
                if (h_bad) begin
                    state_next = qssf_pkg::ST_EMIT;
                end else if (seen_reg == SEEN_ONE) begin
                    div_start  = 1'b1;
                    state_next = qssf_pkg::ST_DIV;
                end else begin
                    mul_a_start = 1'b1;
                    mul_b_start = 1'b1;
                    state_next  = qssf_pkg::ST_MUL1;
                end
            end
            qssf_pkg::ST_MUL1: begin
                if (mul_a_done && mul_b_done) begin
                    state_next = qssf_pkg::ST_FORM;
                end
            end
            qssf_pkg::ST_FORM: begin
                state_next = qssf_pkg::ST_DLOAD;
            end
            qssf_pkg::ST_DLOAD: begin
                div_start  = 1'b1;
                state_next = qssf_pkg::ST_DIV;
            end
            qssf_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    if (seen_reg == SEEN_ONE) begin
                        state_next = qssf_pkg::ST_EMIT;
                    end else begin
                        mul_a_start = 1'b1;
                        state_next  = qssf_pkg::ST_MUL2;
                    end
                end
            end
            qssf_pkg::ST_MUL2: begin
                if (mul_a_done) begin
                    state_next = qssf_pkg::ST_EMIT;
                end
            end
            qssf_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = qssf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qssf_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // step and rise against the stored left end
    always_comb begin
        h_full    = {x_reg[W-1], x_reg} - {prev_pos_reg[W-1], prev_pos_reg};
        dy_full   = {y_reg[W-1], y_reg} - {prev_val_reg[W-1], prev_val_reg};
        h_bad     = h_full[W] || (h_full == '0);
        dy_mag    = dy_full[W] ? ((W+1)'(0) - dy_full) : dy_full;
        slope_mag = slope_reg[W-1] ? (W'(0) - slope_reg) : slope_reg;
    end

    // dy*2^F - s*h, with s*h built from magnitudes
    always_comb begin
        a_ext    = {{(DW-W-1-F){dy_reg[W]}}, dy_reg, {F{1'b0}}};
        pa_ext   = {2'b00, mul_a_prod};
        diff_mag = diff_reg[DW-1] ? (DW'(0) - diff_reg) : diff_reg;
    end

    always_comb begin
        if (state_reg == qssf_pkg::ST_PREP) begin
            div_num = {{(PW-W){1'b0}}, dy_mag[W-1:0], {F{1'b0}}};
            div_den = {{(PW-W){1'b0}}, h_full[W-1:0]};
        end else begin
            div_num = {diff_mag[PW-1:0], {F{1'b0}}};
            div_den = mul_b_prod;
        end
    end

    // quotient limit depends on sign: 2^31 for negative, 2^31-1 otherwise
    always_comb begin
        q_big   = neg_reg ? (div_quo[W-1] && (|div_quo[W-2:0])) : div_quo[W-1];
        div_sat = div_stat.over || q_big;
        if (div_sat) begin
            c_mag   = neg_reg ? qssf_pkg::SAT_MIN : qssf_pkg::SAT_MAX;
            div_val = neg_reg ? qssf_pkg::SAT_MIN : qssf_pkg::SAT_MAX;
        end else begin
            c_mag   = div_quo;
            div_val = neg_reg ? (W'(0) - div_quo) : div_quo;
        end
    end

    always_comb begin
        if (state_reg == qssf_pkg::ST_PREP) begin
            mul_a_mcand  = slope_mag;
            mul_a_mplier = h_full[W-1:0];
        end else begin
            mul_a_mcand  = c_mag;
            mul_a_mplier = h_reg;
        end
    end

    // slope advance: s + 2*c*h / 2^F, truncated toward zero on the magnitude
    always_comb begin
        s_ext  = {{(DW-W){slope_reg[W-1]}}, slope_reg};
        sh_ext = {2'b00, mul_a_prod >> (F - 1)};
        ns_sum = neg_reg ? (s_ext - sh_ext) : (s_ext + sh_ext);
        ns_ovf = !((&ns_sum[DW-1:W-1]) || !(|ns_sum[DW-1:W-1]));
        if (ns_ovf) begin
            ns_sat = ns_sum[DW-1] ? qssf_pkg::SAT_MIN : qssf_pkg::SAT_MAX;
        end else begin
            ns_sat = ns_sum[W-1:0];
        end
    end

    qssf_ser_mul u_mul_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_a_start),
        .mcand   (mul_a_mcand),
        .mplier  (mul_a_mplier),
        .done    (mul_a_done),
        .prod    (mul_a_prod)
    );

    // h squared runs alongside the slope product
    qssf_ser_mul u_mul_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_b_start),
        .mcand   (h_full[W-1:0]),
        .mplier  (h_full[W-1:0]),
        .done    (mul_b_done),
        .prod    (mul_b_prod)
    );

    qssf_ser_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .status  (div_stat),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= qssf_pkg::ST_IDLE;
            prev_pos_reg <= '0;
            prev_val_reg <= '0;
            slope_reg    <= '0;
            seen_reg     <= SEEN_NONE;
            halted_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_acc && s_tuser) begin
                prev_pos_reg <= s_tdata[W-1:0];
                prev_val_reg <= s_tdata[2*W-1:W];
                slope_reg    <= '0;
                seen_reg     <= SEEN_ONE;
                halted_reg   <= 1'b0;
            end
            if (out_load) begin
                if (order_reg) begin
                    halted_reg <= 1'b1;
                end else begin
                    prev_pos_reg <= x_reg;
                    prev_val_reg <= y_reg;
                    slope_reg    <= ns_reg;
                    seen_reg     <= SEEN_SLOPE;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            x_reg <= s_tdata[W-1:0];
            y_reg <= s_tdata[2*W-1:W];
        end
        if (state_reg == qssf_pkg::ST_PREP) begin
            h_reg     <= h_full[W-1:0];
            dy_reg    <= dy_full;
            neg_reg   <= dy_full[W];
            order_reg <= h_bad;
            sat_reg   <= 1'b0;
        end
        if (state_reg == qssf_pkg::ST_FORM) begin
            diff_reg <= slope_reg[W-1] ? (a_ext + pa_ext) : (a_ext - pa_ext);
        end
        if (state_reg == qssf_pkg::ST_DLOAD) begin
            neg_reg <= diff_reg[DW-1];
        end
        if (state_reg == qssf_pkg::ST_DIV && div_stat.done) begin
            sat_reg <= div_sat;
            if (seen_reg == SEEN_ONE) begin
                slope_out_reg <= div_val;
                c_reg         <= '0;
                ns_reg        <= div_val;
            end else begin
                slope_out_reg <= slope_reg;
                c_reg         <= div_val;
            end
        end
        if (state_reg == qssf_pkg::ST_MUL2 && mul_a_done) begin
            ns_reg  <= ns_sat;
            sat_reg <= sat_reg | ns_ovf;
        end
        if (out_load) begin
            if (order_reg) begin
                m_data_reg <= '0;
                m_user_reg <= qssf_pkg::STATUS_ORDER;
            end else begin
                m_data_reg <= {x_reg, c_reg, slope_out_reg, prev_val_reg, prev_pos_reg};
                m_user_reg <= sat_reg ? qssf_pkg::STATUS_SAT : qssf_pkg::STATUS_OK;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

@@ hdl/qssf_checker.sv @@
`default_nettype none
`include "quadratic_spline_segment_fitter_top_defines.svh"

module qssf_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic [qssf_pkg::DATA_IN_W-1:0]      s_tdata,
    input  wire logic                                s_tuser,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [qssf_pkg::DATA_OUT_W-1:0]     m_tdata,
    input  wire logic [1:0]                          m_tuser
);

    localparam int W = qssf_pkg::WORD_W;

    logic start_acc;
    logic order_out;

    assign start_acc = s_tvalid && s_tready && s_tuser && (s_tdata == s_tdata);
    assign order_out = m_tvalid && (m_tuser == qssf_pkg::STATUS_ORDER);

    `QSSF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `QSSF_ASSERT_SAME(a_status_code, m_tvalid, m_tuser == qssf_pkg::STATUS_OK || m_tuser == qssf_pkg::STATUS_ORDER || m_tuser == qssf_pkg::STATUS_SAT, "bad status code")
    `QSSF_ASSERT_SAME(a_order_zero, order_out, m_tdata == '0, "order result carries data")
    `QSSF_ASSERT_SAME(a_piece_span, m_tvalid && !order_out, $signed(m_tdata[5*W-1:4*W]) > $signed(m_tdata[W-1:0]), "piece span not positive")
    `QSSF_ASSERT_NEXT(a_start_absorbed, start_acc, s_tready, "run start request not absorbed")

endmodule

bind quadratic_spline_segment_fitter_top qssf_checker u_qssf_checker (.*);

`default_nettype wire
